/* sv/npcm_pkg.sv */
// Package with the shared types, palette constants and distance functions of the color matcher.
`default_nettype none

package npcm_pkg;

  // Field widths.
  localparam int RGB_W   = 24;
  localparam int CHAN_W  = 8;
  localparam int DIST_W  = 18;
  localparam int IDX_W   = 4;
  localparam int REP_W   = 3;

  // Palette size: the table holds PAL_DEPTH entries, the search uses the first NUM_COLORS.
  localparam int PAL_DEPTH = 16;
  localparam int NUM_COLORS = 16;
  localparam int TREE_LVLS = $clog2(PAL_DEPTH);

  typedef logic [RGB_W-1:0]  pixel_t;
  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [REP_W-1:0]  rep_t;

  // Reset distance of every stored entry; larger than any real distance.
  localparam dist_t DIST_ONES = '1;
  // Largest distance a real match can have (three channels at full swing).
  localparam dist_t DIST_MAX = 18'd195075;
  // A black pixel is replaced by this color.
  localparam pixel_t WHITE = 24'hffffff;

  // Fixed palette.
  localparam pixel_t PALETTE [PAL_DEPTH] = '{
    24'h000000, 24'h010101, 24'h3eb849, 24'h74d07d,
    24'h5955e0, 24'h8076f1, 24'hb95e51, 24'h65dbef,
    24'hdb6559, 24'hff897d, 24'hccc35e, 24'hded087,
    24'h3aa241, 24'hb766b5, 24'hcccccc, 24'hffffff
  };

  // Square of the absolute difference of two channel values.
  function automatic logic [2*CHAN_W-1:0] chan_sq(input chan_t a, input chan_t b);
    chan_t diff;
    diff = (a > b) ? (a - b) : (b - a);
    return (2*CHAN_W)'(diff) * (2*CHAN_W)'(diff);
  endfunction

  // Squared Euclidean distance between two RGB colors.
  function automatic dist_t sq_dist(input pixel_t p, input pixel_t q);
    return DIST_W'(chan_sq(p[23:16], q[23:16]))
         + DIST_W'(chan_sq(p[15:8], q[15:8]))
         + DIST_W'(chan_sq(p[7:0], q[7:0]));
  endfunction

endpackage

`default_nettype wire

/* sv/npcm_in_if.sv */
// Pixel input channel: valid/ready handshake with a 24-bit RGB payload.
`default_nettype none

interface npcm_in_if;
  logic                  valid;
  logic                  ready;
  npcm_pkg::pixel_t      pixel_rgb;

  modport source (output valid, output pixel_rgb, input ready);
  modport sink   (input valid, input pixel_rgb, output ready);
endinterface

`default_nettype wire

/* sv/npcm_out_if.sv */
// Match result channel: valid/ready handshake with index, distance and representative color.
`default_nettype none

interface npcm_out_if;
  logic                  valid;
  logic                  ready;
  npcm_pkg::idx_t        color_index;
  npcm_pkg::dist_t       match_distance;
  npcm_pkg::rep_t        rep_red;
  npcm_pkg::rep_t        rep_green;
  npcm_pkg::rep_t        rep_blue;

  modport source (output valid, output color_index, output match_distance,
                  output rep_red, output rep_green, output rep_blue, input ready);
  modport sink   (input valid, input color_index, input match_distance,
                  input rep_red, input rep_green, input rep_blue, output ready);
endinterface

`default_nettype wire

/* sv/nearest_palette_color_match.sv */
// Top level: four-stage pipeline that matches each pixel to its nearest palette color.
// Each accepted pixel passes through stage A, stage B and stage C into the output register.
// Throughput: one transaction per cycle; the whole pipeline advances whenever the output
// register is empty or its result is being taken, so a stalled output holds every stage.
// Reset (rst_n low, synchronous) empties all stages and sets every stored representative
// color to zero and every stored distance to all ones; no clearing pass is needed.
`default_nettype none

module nearest_palette_color_match (
  input  wire logic   clk,
  input  wire logic   rst_n,
  npcm_in_if.sink     in_chan,
  npcm_out_if.source  out_chan
);

  localparam int PD = npcm_pkg::PAL_DEPTH;
  localparam int TL = npcm_pkg::TREE_LVLS;

  // Pipeline advance: the output register is free or drained this cycle.
  logic pipe_en;

  // Stage A: input register.
  logic              a_valid_r;
  npcm_pkg::pixel_t  a_pix_r;

  // Stage B: substituted pixel and all palette distances.
  logic              b_valid_r;
  npcm_pkg::pixel_t  b_pix_r;
  npcm_pkg::dist_t   b_dist_r [PD];
  npcm_pkg::pixel_t  a_pix_sub;
  npcm_pkg::dist_t   a_dist [PD];

  // Stage C: winning index and distance.
  logic              c_valid_r;
  npcm_pkg::pixel_t  c_pix_r;
  npcm_pkg::dist_t   c_dist_r;
  npcm_pkg::idx_t    c_idx_r;

  // Comparison tree levels; level 0 holds the registered distances.
  npcm_pkg::dist_t   lvl_d [TL+1][PD];
  npcm_pkg::idx_t    lvl_i [TL+1][PD];

  // Per-index representative store.
  npcm_pkg::pixel_t  rep_color_r [PD];
  npcm_pkg::dist_t   rep_dist_r  [PD];
  logic              rep_upd;
  npcm_pkg::pixel_t  rep_sel;

  // Stage D: output register.
  logic              out_valid_r;
  npcm_pkg::idx_t    out_idx_r;
  npcm_pkg::dist_t   out_dist_r;
  npcm_pkg::pixel_t  out_rep_r;

  assign pipe_en       = !out_valid_r || out_chan.ready;
  assign in_chan.ready = pipe_en;

  // Valid bits of all stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      a_valid_r   <= in_chan.valid;
      b_valid_r   <= a_valid_r;
      c_valid_r   <= b_valid_r;
      out_valid_r <= c_valid_r;
    end
  end

  // Stage A payload.
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      a_pix_r <= in_chan.pixel_rgb;
    end
  end

  // A black pixel is searched and stored as white.
  assign a_pix_sub = (a_pix_r == '0) ? npcm_pkg::WHITE : a_pix_r;

  // One distance unit per palette entry; entries past the active count never win.
  for (genvar gi = 0; gi < PD; gi++) begin : g_dist
    if (gi < npcm_pkg::NUM_COLORS) begin : g_act
      assign a_dist[gi] = npcm_pkg::sq_dist(a_pix_sub, npcm_pkg::PALETTE[gi]);
    end else begin : g_pad
      assign a_dist[gi] = npcm_pkg::DIST_ONES;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      b_pix_r  <= a_pix_sub;
      b_dist_r <= a_dist;
    end
  end

  // Minimum search as a pairwise tree; on equal distances the lower index is kept.
  for (genvar gk = 0; gk < PD; gk++) begin : g_leaf
    assign lvl_d[0][gk] = b_dist_r[gk];
    assign lvl_i[0][gk] = npcm_pkg::IDX_W'(gk);
  end

  for (genvar gl = 0; gl < TL; gl++) begin : g_lvl
    for (genvar gn = 0; gn < PD; gn++) begin : g_node
      if (gn < (PD >> (gl + 1))) begin : g_cmp
        always_comb begin
          if (lvl_d[gl][2*gn+1] < lvl_d[gl][2*gn]) begin
            lvl_d[gl+1][gn] = lvl_d[gl][2*gn+1];
            lvl_i[gl+1][gn] = lvl_i[gl][2*gn+1];
          end else begin
            lvl_d[gl+1][gn] = lvl_d[gl][2*gn];
            lvl_i[gl+1][gn] = lvl_i[gl][2*gn];
          end
        end
      end else begin : g_idle
        assign lvl_d[gl+1][gn] = npcm_pkg::DIST_ONES;
        assign lvl_i[gl+1][gn] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      c_pix_r  <= b_pix_r;
      c_dist_r <= lvl_d[TL][0];
      c_idx_r  <= lvl_i[TL][0];
    end
  end

  // Store update: a strictly closer match replaces the entry of the winning index.
  assign rep_upd = c_dist_r < rep_dist_r[c_idx_r];
  assign rep_sel = rep_upd ? c_pix_r : rep_color_r[c_idx_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PD; i++) begin
        rep_color_r[i] <= '0;
        rep_dist_r[i]  <= npcm_pkg::DIST_ONES;
      end
    end else if (pipe_en && c_valid_r && rep_upd) begin
      rep_color_r[c_idx_r] <= c_pix_r;
      rep_dist_r[c_idx_r]  <= c_dist_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_idx_r  <= c_idx_r;
      out_dist_r <= c_dist_r;
      out_rep_r  <= rep_sel;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.color_index    = out_idx_r;
  assign out_chan.match_distance = out_dist_r;
  assign out_chan.rep_red        = out_rep_r[23:21];
  assign out_chan.rep_green      = out_rep_r[15:13];
  assign out_chan.rep_blue       = out_rep_r[7:5];

`ifndef SYNTHESIS
  // A reported distance comes from a real palette comparison.
  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_dist_r <= npcm_pkg::DIST_MAX))
    else $error("match distance exceeds the largest possible distance");

  // The winner is always one of the active palette entries.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (int'(out_idx_r) < npcm_pkg::NUM_COLORS))
    else $error("color index beyond the active palette");

  // The store entry of a reported index is never farther than the reported distance.
  a_store_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (rep_dist_r[out_idx_r] <= out_dist_r))
    else $error("stored distance larger than the match that was reported");
`endif

endmodule

`default_nettype wire

/* sim/tb.sv */
// Self-checking bench for the palette color matcher against a built-in predictor.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned      CYCLE_LIMIT   = 200000;
  localparam int unsigned      DRAIN_CYCLES  = 12;
  localparam int unsigned      RANDOM_PIXELS = 600;
  localparam int unsigned      REPORT_LIMIT  = 10;
  localparam npcm_pkg::pixel_t BLACK_PIX     = 24'h000000;
  localparam npcm_pkg::pixel_t WHITE_PIX     = 24'hffffff;

  // Palette as the matcher is specified to hold it.
  localparam npcm_pkg::pixel_t SWATCH [16] = '{
    24'h000000, 24'h010101, 24'h3eb849, 24'h74d07d,
    24'h5955e0, 24'h8076f1, 24'hb95e51, 24'h65dbef,
    24'hdb6559, 24'hff897d, 24'hccc35e, 24'hded087,
    24'h3aa241, 24'hb766b5, 24'hcccccc, 24'hffffff
  };

  typedef struct packed {
    npcm_pkg::idx_t  color_index;
    npcm_pkg::dist_t match_distance;
    npcm_pkg::rep_t  rep_red;
    npcm_pkg::rep_t  rep_green;
    npcm_pkg::rep_t  rep_blue;
  } match_t;

  logic clk;
  logic rst_n;

  npcm_in_if  pix_chan ();
  npcm_out_if match_chan ();

  nearest_palette_color_match dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (pix_chan),
    .out_chan (match_chan)
  );

  // Pixels waiting to be sent and matches waiting to come back.
  npcm_pkg::pixel_t pixel_stream [$];
  match_t           pending_matches [$];

  // Shadow copy of the per-index closest colors and their distances.
  npcm_pkg::pixel_t shadow_color [16];
  int unsigned      shadow_dist [16];

  logic        in_taken;
  logic        out_taken;
  int unsigned in_wait, out_wait, in_calm, out_calm;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned results_checked;
  int unsigned pixels_sent, black_pixels, tie_pixels, store_updates;

  // Free-running clock, 8 ns period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Squared RGB distance between two colors.
  function automatic int unsigned color_gap(input npcm_pkg::pixel_t a,
                                            input npcm_pkg::pixel_t b);
    int dr, dg, db;
    dr = int'(a[23:16]) - int'(b[23:16]);
    dg = int'(a[15:8]) - int'(b[15:8]);
    db = int'(a[7:0]) - int'(b[7:0]);
    return int'(dr * dr + dg * dg + db * db);
  endfunction

  // Expected result for one accepted pixel; also updates the shadow store.
  function automatic match_t predict_match(input npcm_pkg::pixel_t raw);
    npcm_pkg::pixel_t pix;
    npcm_pkg::pixel_t rep;
    int unsigned      best_d, d;
    npcm_pkg::idx_t   best_i;
    bit               tied;
    match_t           m;
    pix    = (raw == BLACK_PIX) ? WHITE_PIX : raw;
    best_d = 32'hffff_ffff;
    best_i = '0;
    tied   = 1'b0;
    if (raw == BLACK_PIX) begin
      black_pixels++;
    end
    for (int i = 0; i < npcm_pkg::NUM_COLORS; i++) begin
      d = color_gap(pix, SWATCH[i]);
      if (d < best_d) begin
        best_d = d;
        best_i = npcm_pkg::idx_t'(i);
        tied   = 1'b0;
      end else if (d == best_d) begin
        tied = 1'b1;
      end
    end
    if (tied) begin
      tie_pixels++;
    end
    // The store keeps a new color only when it is strictly closer.
    if (best_d < shadow_dist[best_i]) begin
      shadow_color[best_i] = pix;
      shadow_dist[best_i]  = best_d;
      store_updates++;
    end
    rep              = shadow_color[best_i];
    m.color_index    = best_i;
    m.match_distance = npcm_pkg::dist_t'(best_d);
    m.rep_red        = rep[23:21];
    m.rep_green      = rep[15:13];
    m.rep_blue       = rep[7:5];
    return m;
  endfunction

  // Channel value moved by a random offset and clamped to the channel range.
  function automatic npcm_pkg::chan_t nudge(input int base, input int span);
    int v;
    v = base + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) begin
      v = 0;
    end else if (v > 255) begin
      v = 255;
    end
    return npcm_pkg::chan_t'(v);
  endfunction

  // Wait before the next transaction: random gaps, with runs of back-to-back traffic.
  function automatic int unsigned pick_wait(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  // Sample both channels at the rising edge; check results, then predict new pixels.
  always @(posedge clk) begin : scoreboard
    match_t got;
    match_t want;
    in_taken  <= rst_n && pix_chan.valid && pix_chan.ready;
    out_taken <= rst_n && match_chan.valid && match_chan.ready;
    if (rst_n && match_chan.valid && match_chan.ready) begin
      got = {match_chan.color_index, match_chan.match_distance,
             match_chan.rep_red, match_chan.rep_green, match_chan.rep_blue};
      if (pending_matches.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
          $display("Unexpected result: index %0d dist %0d rep %0d/%0d/%0d",
                   got.color_index, got.match_distance,
                   got.rep_red, got.rep_green, got.rep_blue);
        end
      end else begin
        want = pending_matches.pop_front();
        results_checked++;
        if (got !== want) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("Result %0d: expected index %0d dist %0d rep %0d/%0d/%0d",
                     results_checked, want.color_index, want.match_distance,
                     want.rep_red, want.rep_green, want.rep_blue);
            $display("           got      index %0d dist %0d rep %0d/%0d/%0d",
                     got.color_index, got.match_distance,
                     got.rep_red, got.rep_green, got.rep_blue);
          end
        end
      end
    end
    if (rst_n && pix_chan.valid && pix_chan.ready) begin
      pending_matches.push_back(predict_match(pix_chan.pixel_rgb));
      pixels_sent++;
    end
  end

  // Pixel driver: presents the next pixel at the falling edge after its wait.
  always @(negedge clk) begin : pixel_driver
    if (!rst_n) begin
      pix_chan.valid <= 1'b0;
    end else if (!pix_chan.valid || in_taken) begin
      if (in_wait != 0) begin
        pix_chan.valid <= 1'b0;
        in_wait        <= in_wait - 1;
      end else if (pixel_stream.size() != 0) begin
        pix_chan.valid     <= 1'b1;
        pix_chan.pixel_rgb <= pixel_stream.pop_front();
        in_wait            <= pick_wait(in_calm);
      end else begin
        pix_chan.valid <= 1'b0;
      end
    end
  end

  // Result taker: drops ready for a random number of cycles after each transaction.
  always @(negedge clk) begin : result_taker
    int unsigned w;
    if (!rst_n) begin
      match_chan.ready <= 1'b0;
    end else if (out_wait != 0) begin
      match_chan.ready <= 1'b0;
      out_wait         <= out_wait - 1;
    end else if (out_taken) begin
      w = pick_wait(out_calm);
      match_chan.ready <= (w == 0);
      out_wait         <= (w == 0) ? 0 : w - 1;
    end else begin
      match_chan.ready <= 1'b1;
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d pixels unsent, %0d results outstanding",
               cycle_count, pixel_stream.size(), pending_matches.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    npcm_pkg::pixel_t pix;
    npcm_pkg::pixel_t a_col, b_col;
    int unsigned      ties_found;
    int unsigned      best_d, d, at_best;

    rst_n               = 1'b0;
    pix_chan.valid      = 1'b0;
    pix_chan.pixel_rgb  = '0;
    match_chan.ready    = 1'b0;
    in_taken            = 1'b0;
    out_taken           = 1'b0;
    in_wait             = 0;
    out_wait            = 0;
    in_calm             = 0;
    out_calm            = 0;
    cycle_count         = 0;
    fail_count          = 0;
    results_checked     = 0;
    pixels_sent         = 0;
    black_pixels        = 0;
    tie_pixels          = 0;
    store_updates       = 0;
    ties_found          = 0;
    for (int i = 0; i < 16; i++) begin
      shadow_color[i] = '0;
      shadow_dist[i]  = (1 << npcm_pkg::DIST_W) - 1;
    end

    // Store updates near one entry: first match, equal, closer, then farther.
    pixel_stream.push_back(24'hb95e60);
    pixel_stream.push_back(24'hb95e60);
    pixel_stream.push_back(24'hb95e58);
    pixel_stream.push_back(24'hb95e70);
    // Every palette entry exactly; the first one is black and so becomes white.
    for (int i = 0; i < 16; i++) begin
      pixel_stream.push_back(SWATCH[i]);
    end
    // Channel extremes.
    pixel_stream.push_back(24'h000001);
    pixel_stream.push_back(24'hff0000);
    pixel_stream.push_back(24'h0000ff);

    // Look for a few pixels at equal distance from two nearest entries.
    for (int t = 0; t < 200000 && ties_found < 3; t++) begin
      a_col = SWATCH[$urandom_range(0, 15)];
      b_col = SWATCH[$urandom_range(0, 15)];
      pix = {nudge((int'(a_col[23:16]) + int'(b_col[23:16])) / 2, 4),
             nudge((int'(a_col[15:8]) + int'(b_col[15:8])) / 2, 4),
             nudge((int'(a_col[7:0]) + int'(b_col[7:0])) / 2, 4)};
      best_d  = 32'hffff_ffff;
      at_best = 0;
      for (int i = 0; i < npcm_pkg::NUM_COLORS; i++) begin
        d = color_gap(pix, SWATCH[i]);
        if (d < best_d) begin
          best_d  = d;
          at_best = 1;
        end else if (d == best_d) begin
          at_best++;
        end
      end
      if (pix != BLACK_PIX && at_best > 1) begin
        pixel_stream.push_back(pix);
        ties_found++;
      end
    end

    // Random pixels: mostly uniform, many close to palette entries, some black or saturated.
    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      case ($urandom_range(0, 19))
        0: begin
          pix = BLACK_PIX;
        end
        1, 2: begin
          pix = {$urandom_range(0, 1) ? 8'hff : 8'h00,
                 $urandom_range(0, 1) ? 8'hff : 8'h00,
                 $urandom_range(0, 1) ? 8'hff : 8'h00};
        end
        3, 4, 5, 6, 7, 8, 9: begin
          a_col = SWATCH[$urandom_range(0, 15)];
          pix = {nudge(int'(a_col[23:16]), 12), nudge(int'(a_col[15:8]), 12),
                 nudge(int'(a_col[7:0]), 12)};
        end
        default: begin
          pix = npcm_pkg::pixel_t'($urandom());
        end
      endcase
      pixel_stream.push_back(pix);
    end

    // Hold reset low over rising edges, then release it at a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every pixel to be taken and every match to come back.
    while (pixel_stream.size() != 0 || pix_chan.valid) @(posedge clk);
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    fail_count += pending_matches.size();

    $display("Matched %0d pixels: %0d black, %0d on a distance tie, %0d store updates",
             pixels_sent, black_pixels, tie_pixels, store_updates);
    $display("Checked %0d results in %0d cycles, %0d failures",
             results_checked, cycle_count, fail_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
sv/npcm_pkg.sv
sv/npcm_in_if.sv
sv/npcm_out_if.sv
sv/nearest_palette_color_match.sv
sim/tb.sv
